FILE: src/rgb_to_nv12_converter_macros.svh
// ----------------------------------------------------------------------------
// RGB to NV12 converter assertion macros
// Shared property forms for the converter checks; clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_NV12_CONVERTER_MACROS_SVH
`define RGB_TO_NV12_CONVERTER_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define RTNV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb_to_nv12_converter: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger
`define RTNV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb_to_nv12_converter: next-cycle check failed");

`endif

FILE: src/rtnv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to NV12 converter package
// Field widths, BT.601 coefficients, register map and shared types.
// ----------------------------------------------------------------------------
package rtnv_pkg;

  // Default frame limits
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Field widths
  localparam int COLOR_W     = 8;
  localparam int LUMA_IDX_W  = 24;
  localparam int CHROMA_IDX_W = 25;
  localparam int CFG_W       = 13;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // Register map: index is the word address bit
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(1280);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(640);

  // Luma coefficients (unsigned path)
  localparam logic [15:0] Y_COEF_R = 16'd66;
  localparam logic [15:0] Y_COEF_G = 16'd129;
  localparam logic [15:0] Y_COEF_B = 16'd25;
  localparam logic [15:0] Y_ROUND  = 16'd128;
  localparam logic [7:0]  Y_OFFSET = 8'd16;

  // Chroma coefficients (signed path)
  localparam logic signed [16:0] CB_COEF_R = -17'sd38;
  localparam logic signed [16:0] CB_COEF_G = -17'sd74;
  localparam logic signed [16:0] CB_COEF_B = 17'sd112;
  localparam logic signed [16:0] CR_COEF_R = 17'sd112;
  localparam logic signed [16:0] CR_COEF_G = -17'sd94;
  localparam logic signed [16:0] CR_COEF_B = -17'sd18;
  localparam logic signed [16:0] C_ROUND   = 17'sd128;
  localparam logic [7:0]         C_BIAS    = 8'h80;

  // Chroma offset advance per chroma word (Cb then Cr)
  localparam logic [CHROMA_IDX_W-1:0] CHROMA_STEP = CHROMA_IDX_W'(2);

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_t;

  // Raster position of one pixel, as seen by the output word
  typedef struct packed {
    logic [LUMA_IDX_W-1:0]   luma_index;
    logic                    chroma_valid;
    logic [CHROMA_IDX_W-1:0] chroma_index;
    logic                    frame_end;
  } pos_t;

  // Arithmetic shift by 8, saturate to signed 8 bits, add the bias mod 256
  function automatic logic [7:0] chroma_byte(input logic signed [16:0] acc);
    logic signed [16:0] q;
    logic [7:0]         s;
    q = acc >>> 8;
    if (q > 17'sd127) begin
      s = 8'h7f;
    end else if (q < -17'sd128) begin
      s = 8'h80;
    end else begin
      s = q[7:0];
    end
    return s ^ C_BIAS;
  endfunction

endpackage

FILE: src/rtnv_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one BGR pixel per word.
// ----------------------------------------------------------------------------
interface rtnv_pixel_if import rtnv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

FILE: src/rtnv_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the luma, chroma and buffer offsets of a pixel.
// ----------------------------------------------------------------------------
interface rtnv_result_if import rtnv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [COLOR_W-1:0]      luma;
  logic [LUMA_IDX_W-1:0]   luma_index;
  logic                    chroma_valid;
  logic [COLOR_W-1:0]      blue_difference;
  logic [COLOR_W-1:0]      red_difference;
  logic [CHROMA_IDX_W-1:0] chroma_index;
  logic                    frame_end;

  modport source (output valid, luma, luma_index, chroma_valid, blue_difference,
                  red_difference, chroma_index, frame_end, input ready);
  modport sink   (input valid, luma, luma_index, chroma_valid, blue_difference,
                  red_difference, chroma_index, frame_end, output ready);
endinterface

FILE: src/rtnv_config_regs.sv
// ----------------------------------------------------------------------------
// Frame size registers
// APB write/read of frame width and height; gives the clamped sizes.
// ----------------------------------------------------------------------------
module rtnv_config_regs import rtnv_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [WW-1:0]         frame_width,
  output logic [HW-1:0]         frame_height
);

  localparam int CLW = CFG_W + 1;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic             reg_index;
  logic             wr_en;
  logic [CLW-1:0]   width_ext;
  logic [CLW-1:0]   height_ext;
  logic [CLW-1:0]   width_clamp;
  logic [CLW-1:0]   height_clamp;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite && pready;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= FRAME_WIDTH_RESET;
      height_reg <= FRAME_HEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_FRAME_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the raw register value
  always_comb begin
    case (reg_index)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
      default:          prdata = '0;
    endcase
  end

  // Clamp the sizes to one through the configured maximum
  assign width_ext  = {1'b0, width_reg};
  assign height_ext = {1'b0, height_reg};

  always_comb begin
    if (width_reg == '0) begin
      width_clamp = CLW'(1);
    end else if (width_ext > CLW'(MAX_WIDTH)) begin
      width_clamp = CLW'(MAX_WIDTH);
    end else begin
      width_clamp = width_ext;
    end
    if (height_reg == '0) begin
      height_clamp = CLW'(1);
    end else if (height_ext > CLW'(MAX_HEIGHT)) begin
      height_clamp = CLW'(MAX_HEIGHT);
    end else begin
      height_clamp = height_ext;
    end
  end

  assign frame_width  = WW'(width_clamp);
  assign frame_height = HW'(height_clamp);

endmodule

FILE: src/rtnv_raster_counter.sv
// ----------------------------------------------------------------------------
// Raster position counter
// Tracks column and row of the next pixel and the NV12 luma and chroma
// offsets; advances once per accepted pixel word.
// ----------------------------------------------------------------------------
module rtnv_raster_counter import rtnv_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [WW-1:0] frame_width,
  input  logic [HW-1:0] frame_height,
  output pos_t          pos
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CW1 = CW + 1;
  localparam int RW1 = RW + 1;

  logic [CW-1:0]           column_count;
  logic [RW-1:0]           row_count;
  logic [LUMA_IDX_W-1:0]   luma_offset;
  logic [CHROMA_IDX_W-1:0] chroma_offset;

  logic                    frame_start;
  logic [WW+HW-1:0]        area_full;
  logic [CHROMA_IDX_W-1:0] chroma_base;
  logic                    chroma_valid;
  logic                    row_end;
  logic                    frame_end;

  // Reload the chroma base with the frame size at the first pixel
  assign frame_start  = (column_count == '0) && (row_count == '0);
  assign area_full    = frame_width * frame_height;
  assign chroma_base  = frame_start ? CHROMA_IDX_W'(area_full) : chroma_offset;

  // Chroma on even rows at even columns
  assign chroma_valid = !row_count[0] && !column_count[0];

  // Row and frame ends against the current limits
  assign row_end   = (CW1'(column_count) + CW1'(1)) >= CW1'(frame_width);
  assign frame_end = row_end && ((RW1'(row_count) + RW1'(1)) >= RW1'(frame_height));

  always_comb begin
    pos.luma_index   = luma_offset;
    pos.chroma_valid = chroma_valid;
    pos.chroma_index = chroma_valid ? chroma_base : '0;
    pos.frame_end    = frame_end;
  end

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      luma_offset   <= '0;
      chroma_offset <= '0;
    end else if (advance) begin
      chroma_offset <= chroma_valid ? chroma_base + CHROMA_STEP : chroma_base;
      if (frame_end) begin
        column_count <= '0;
        row_count    <= '0;
        luma_offset  <= '0;
      end else if (row_end) begin
        column_count <= '0;
        row_count    <= row_count + RW'(1);
        luma_offset  <= luma_offset + LUMA_IDX_W'(1);
      end else begin
        column_count <= column_count + CW'(1);
        luma_offset  <= luma_offset + LUMA_IDX_W'(1);
      end
    end
  end

endmodule

FILE: src/rtnv_color_matrix.sv
// ----------------------------------------------------------------------------
// BT.601 color matrix
// Constant-coefficient conversion of one pixel to Y, Cb and Cr bytes.
// ----------------------------------------------------------------------------
module rtnv_color_matrix import rtnv_pkg::*; (
  input  pixel_t             pixel,
  output logic [COLOR_W-1:0] luma,
  output logic [COLOR_W-1:0] blue_difference,
  output logic [COLOR_W-1:0] red_difference
);

  logic [15:0]        y_acc;
  logic signed [16:0] red_s;
  logic signed [16:0] green_s;
  logic signed [16:0] blue_s;
  logic signed [16:0] cb_acc;
  logic signed [16:0] cr_acc;

  // Luma: weighted sum, round, shift, offset
  assign y_acc = Y_COEF_R * 16'(pixel.red) + Y_COEF_G * 16'(pixel.green)
               + Y_COEF_B * 16'(pixel.blue) + Y_ROUND;
  assign luma  = y_acc[15:8] + Y_OFFSET;

  // Chroma: signed weighted sums
  assign red_s   = signed'({9'd0, pixel.red});
  assign green_s = signed'({9'd0, pixel.green});
  assign blue_s  = signed'({9'd0, pixel.blue});

  assign cb_acc = CB_COEF_R * red_s + CB_COEF_G * green_s + CB_COEF_B * blue_s + C_ROUND;
  assign cr_acc = CR_COEF_R * red_s + CR_COEF_G * green_s + CR_COEF_B * blue_s + C_ROUND;

  assign blue_difference = chroma_byte(cb_acc);
  assign red_difference  = chroma_byte(cr_acc);

endmodule

FILE: src/rgb_to_nv12_converter.sv
// ----------------------------------------------------------------------------
// RGB to NV12 converter
// BT.601 BGR pixel stream to NV12 luma and interleaved chroma bytes, with
// the buffer offset of each byte and an end-of-frame mark.
// ----------------------------------------------------------------------------
//  channel | dir | word contents
//  --------+-----+-----------------------------------------------------------
//  pixel   | in  | blue, green, red
//  result  | out | luma, luma_index, chroma_valid, blue_difference,
//          |     | red_difference, chroma_index, frame_end
//  apb     | cfg | frame_width at 0x0, frame_height at 0x4
//
//  One pixel per clock while the result channel keeps taking words; a result
//  is offered once its pixel has passed the input register and the result
//  register around the color matrix. Reset leaves 1280x640 and starts a new
//  frame; no clearing pass. A stalled result holds both stages; the input
//  takes a word whenever the input register is empty or moves on.
// ----------------------------------------------------------------------------
`include "rgb_to_nv12_converter_macros.svh"

module rgb_to_nv12_converter import rtnv_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  rtnv_pixel_if.sink            pixel,
  rtnv_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0] frame_width;
  logic [HW-1:0] frame_height;

  logic   in_take;
  logic   out_take;
  logic   accept;
  pos_t   cur_pos;

  // Input register
  logic   s1_valid;
  pixel_t s1_pixel;
  pos_t   s1_pos;

  // Color matrix outputs
  logic [COLOR_W-1:0] mat_luma;
  logic [COLOR_W-1:0] mat_cb;
  logic [COLOR_W-1:0] mat_cr;

  // Result register
  logic                    s2_valid;
  logic [COLOR_W-1:0]      res_luma;
  logic [LUMA_IDX_W-1:0]   res_luma_index;
  logic                    res_chroma_valid;
  logic [COLOR_W-1:0]      res_cb;
  logic [COLOR_W-1:0]      res_cr;
  logic [CHROMA_IDX_W-1:0] res_chroma_index;
  logic                    res_frame_end;

  // Terms used by the checks
  logic res_chroma_zero;
  logic pos_at_origin;

  rtnv_config_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_config (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height)
  );

  // Stage flow: drain the result register, then refill the input register
  assign out_take    = !s2_valid || result.ready;
  assign in_take     = !s1_valid || out_take;
  assign pixel.ready = in_take;
  assign accept      = pixel.valid && in_take;

  rtnv_raster_counter #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_counter (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pos          (cur_pos)
  );

  // Capture the pixel and its raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel.blue  <= pixel.blue;
      s1_pixel.green <= pixel.green;
      s1_pixel.red   <= pixel.red;
      s1_pos         <= cur_pos;
    end
  end

  rtnv_color_matrix u_matrix (
    .pixel           (s1_pixel),
    .luma            (mat_luma),
    .blue_difference (mat_cb),
    .red_difference  (mat_cr)
  );

  // Load the result register; drop chroma on pixels that carry none
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (out_take) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid) begin
      res_luma         <= mat_luma;
      res_luma_index   <= s1_pos.luma_index;
      res_chroma_valid <= s1_pos.chroma_valid;
      res_cb           <= s1_pos.chroma_valid ? mat_cb : '0;
      res_cr           <= s1_pos.chroma_valid ? mat_cr : '0;
      res_chroma_index <= s1_pos.chroma_index;
      res_frame_end    <= s1_pos.frame_end;
    end
  end

  assign result.valid           = s2_valid;
  assign result.luma            = res_luma;
  assign result.luma_index      = res_luma_index;
  assign result.chroma_valid    = res_chroma_valid;
  assign result.blue_difference = res_cb;
  assign result.red_difference  = res_cr;
  assign result.chroma_index    = res_chroma_index;
  assign result.frame_end       = res_frame_end;

  assign res_chroma_zero = (res_cb == '0) && (res_cr == '0) && (res_chroma_index == '0);
  assign pos_at_origin   = (cur_pos.luma_index == '0) && cur_pos.chroma_valid;

  // Luma stays in the studio range
  `RTNV_ASSERT_SAME(a_luma_range, s2_valid, (res_luma >= 8'd16) && (res_luma <= 8'd235))

  // A word without chroma carries zero chroma fields
  `RTNV_ASSERT_SAME(a_chroma_zero, s2_valid && !res_chroma_valid, res_chroma_zero)

  // The pixel after a frame end starts the next frame at the origin
  `RTNV_ASSERT_NEXT(a_frame_restart, accept && cur_pos.frame_end, pos_at_origin)

endmodule

FILE: tb/rgb_to_nv12_converter_test.sv
// ----------------------------------------------------------------------------
// RGB to NV12 converter testbench
// Drives BGR pixel words through the converter under several frame sizes:
// register extremes, odd and narrow widths, clamped sizes and resizes in the
// middle of a frame. A local BT.601/NV12 predictor computes every result
// word, and each word taken from the result channel is compared field by
// field. Both channels idle and stall at random; one long receiver hold-off
// forces the converter to stall its input.
// ----------------------------------------------------------------------------
module rgb_to_nv12_converter_test;
  import rtnv_pkg::*;

  localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};
  localparam int QUIET_LIMIT = 1000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [COLOR_W-1:0]      luma;
    logic [LUMA_IDX_W-1:0]   luma_index;
    logic                    chroma_valid;
    logic [COLOR_W-1:0]      blue_difference;
    logic [COLOR_W-1:0]      red_difference;
    logic [CHROMA_IDX_W-1:0] chroma_index;
    logic                    frame_end;
  } nv12_word_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rtnv_pixel_if  pix ();
  rtnv_result_if res ();

  rgb_to_nv12_converter dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pix.sink),
    .result  (res.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and the raster counters
  logic [CFG_W-1:0]        frame_width_reg  = FRAME_WIDTH_RESET;
  logic [CFG_W-1:0]        frame_height_reg = FRAME_HEIGHT_RESET;
  logic [11:0]             col_pos    = '0;
  logic [11:0]             row_pos    = '0;
  logic [LUMA_IDX_W-1:0]   luma_pos   = '0;
  logic [CHROMA_IDX_W-1:0] chroma_pos = CHROMA_IDX_W'(1280 * 640);

  nv12_word_t queued_words[$];

  bit idle_on   = 1'b0;
  int long_hold = 0;
  int fail_count      = 0;
  int pixels_sent     = 0;
  int words_checked   = 0;
  int chroma_seen     = 0;
  int frame_ends_seen = 0;
  int frame_settings  = 0;
  int quiet_cycles    = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Short gaps mostly, now and then a long one
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      return $urandom_range(1, 3);
    end else if (pick < 18) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Shift right arithmetic, saturate to signed 8 bits, add the bias
  function automatic logic [7:0] chroma_code(input int acc);
    int q;
    q = acc >>> 8;
    if (q > 127) begin
      q = 127;
    end
    if (q < -128) begin
      q = -128;
    end
    return 8'(q + 128);
  endfunction

  // Convert one pixel and advance the raster position
  function automatic nv12_word_t convert_pixel(input pixel_t px);
    nv12_word_t  wd;
    int unsigned w;
    int unsigned h;
    int unsigned ysum;
    int          r;
    int          g;
    int          b;
    bit          row_end;
    bit          last_pixel;
    w = 32'(frame_width_reg);
    h = 32'(frame_height_reg);
    if (w < 1) begin
      w = 1;
    end
    if (w > DEF_MAX_WIDTH) begin
      w = DEF_MAX_WIDTH;
    end
    if (h < 1) begin
      h = 1;
    end
    if (h > DEF_MAX_HEIGHT) begin
      h = DEF_MAX_HEIGHT;
    end
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    // reload the chroma plane base at the first pixel of a frame
    if (col_pos == 0 && row_pos == 0) begin
      chroma_pos = CHROMA_IDX_W'(w * h);
    end
    ysum = (66 * r + 129 * g + 25 * b + 128) >> 8;
    if (ysum > 255) begin
      ysum = 255;
    end
    wd.luma       = 8'(ysum + 16);
    wd.luma_index = luma_pos;
    wd.chroma_valid = !row_pos[0] && !col_pos[0];
    if (wd.chroma_valid) begin
      wd.blue_difference = chroma_code(-38 * r - 74 * g + 112 * b + 128);
      wd.red_difference  = chroma_code(112 * r - 94 * g - 18 * b + 128);
      wd.chroma_index    = chroma_pos;
      chroma_pos         = chroma_pos + CHROMA_IDX_W'(2);
    end else begin
      wd.blue_difference = '0;
      wd.red_difference  = '0;
      wd.chroma_index    = '0;
    end
    row_end    = (col_pos + 32'd1) >= w;
    last_pixel = row_end && ((row_pos + 32'd1) >= h);
    wd.frame_end = last_pixel;
    if (last_pixel) begin
      col_pos  = '0;
      row_pos  = '0;
      luma_pos = '0;
    end else if (row_end) begin
      col_pos  = '0;
      row_pos  = row_pos + 12'd1;
      luma_pos = luma_pos + 24'd1;
    end else begin
      col_pos  = col_pos + 12'd1;
      luma_pos = luma_pos + 24'd1;
    end
    return wd;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    // one pixel in ten uses only the channel extremes
    if ($urandom_range(0, 9) == 0) begin
      px.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
      px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
      px.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
    end else begin
      px.blue  = 8'($urandom_range(0, 255));
      px.green = 8'($urandom_range(0, 255));
      px.red   = 8'($urandom_range(0, 255));
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) begin
      $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    end
  endtask

  // Offer one pixel word and hold it until the converter takes it
  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.blue  <= px.blue;
    pix.green <= px.green;
    pix.red   <= px.red;
    do @(posedge clk); while (!pix.ready);
    queued_words.push_back(convert_pixel(px));
    pixels_sent++;
  endtask

  // Drop valid and wait for every predicted word to come back
  task automatic wait_for_results();
    pix.valid <= 1'b0;
    while (queued_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == WIDTH_ADDR) begin
      frame_width_reg = data[CFG_W-1:0];
    end else if (addr == HEIGHT_ADDR) begin
      frame_height_reg = data[CFG_W-1:0];
    end
  endtask

  task automatic check_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [CFG_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== APB_DATA_W'(want)) begin
      report_mismatch(addr == WIDTH_ADDR ? "frame_width read" : "frame_height read",
                      prdata, APB_DATA_W'(want));
    end
  endtask

  // Write both size registers with junk in the unused bits, then read back
  task automatic set_frame(input int unsigned w, input int unsigned h);
    write_register(WIDTH_ADDR, {19'($urandom), CFG_W'(w)});
    write_register(HEIGHT_ADDR, {19'($urandom), CFG_W'(h)});
    check_register(WIDTH_ADDR, frame_width_reg);
    check_register(HEIGHT_ADDR, frame_height_reg);
    frame_settings++;
  endtask

  // Stream random pixels, switching idling on and off in stretches
  task automatic stream_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      send_pixel(random_pixel());
      if ($urandom_range(0, 59) == 0) begin
        wait_for_results();
      end
    end
    wait_for_results();
  endtask

  task automatic run_frames(input int unsigned w, input int unsigned h, input int count);
    set_frame(w, h);
    stream_pixels(count);
  endtask

  // Reset values, then channel extremes and primaries at the reset size
  task automatic test_reset_state();
    pixel_t corners[8];
    check_register(WIDTH_ADDR, FRAME_WIDTH_RESET);
    check_register(HEIGHT_ADDR, FRAME_HEIGHT_RESET);
    corners[0] = '{8'h00, 8'h00, 8'h00};
    corners[1] = '{8'hff, 8'hff, 8'hff};
    corners[2] = '{8'h00, 8'h00, 8'hff};
    corners[3] = '{8'h00, 8'hff, 8'h00};
    corners[4] = '{8'hff, 8'h00, 8'h00};
    corners[5] = '{8'hff, 8'hff, 8'h00};
    corners[6] = '{8'h00, 8'hff, 8'hff};
    corners[7] = '{8'hff, 8'h00, 8'hff};
    idle_on = 1'b0;
    foreach (corners[i]) begin
      send_pixel(corners[i]);
    end
    wait_for_results();
  endtask

  task automatic test_small_frames();
    run_frames(16, 2, 96);
    run_frames(32, 4, 160);
    run_frames(2, 2, 40);
  endtask

  // Widths off the multiple of sixteen, odd ones included
  task automatic test_odd_widths();
    run_frames(3, 3, 54);
    run_frames(5, 4, 60);
    run_frames(17, 1, 51);
  endtask

  // Zero and oversized registers clamp to 1 and the maximum
  task automatic test_clamped_sizes();
    run_frames(0, 0, 20);
    run_frames(1, 8191, 30);
    run_frames(8191, 0, 30);
  endtask

  // Shrink the frame while the counters are past the new limits
  task automatic test_midframe_resize();
    run_frames(4096, 2, 40);
    write_register(WIDTH_ADDR, 32'd16);
    stream_pixels(60);
    write_register(HEIGHT_ADDR, 32'd4);
    stream_pixels(20);
    write_register(HEIGHT_ADDR, 32'd1);
    stream_pixels(10);
  endtask

  // Hold the receiver off while the sender keeps offering back to back
  task automatic test_backpressure();
    set_frame(16, 3);
    idle_on   = 1'b0;
    long_hold = 80;
    for (int i = 0; i < 48; i++) begin
      send_pixel(random_pixel());
    end
    wait_for_results();
  endtask

  // Largest frame: chroma base at its largest value
  task automatic test_largest_frame();
    run_frames(4096, 4096, 40);
  endtask

  task automatic test_random_sizes();
    for (int k = 0; k < 4; k++) begin
      run_frames($urandom_range(1, 40), $urandom_range(1, 8), 20);
    end
  endtask

  // Receiver: random stalls, plus the long hold-off on request
  initial begin : drive_ready
    int hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        hold_left = long_hold;
        long_hold = 0;
      end
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        hold_left = gap_length() - 1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin : check_words
    nv12_word_t want;
    if (!rst && res.valid && res.ready) begin
      if (queued_words.size() == 0) begin
        report_mismatch("word with no pixel pending, luma_index", 32'(res.luma_index), 0);
      end else begin
        want = queued_words.pop_front();
        words_checked++;
        if (want.chroma_valid) begin
          chroma_seen++;
        end
        if (want.frame_end) begin
          frame_ends_seen++;
        end
        if (res.luma !== want.luma) begin
          report_mismatch("luma", 32'(res.luma), 32'(want.luma));
        end
        if (res.luma_index !== want.luma_index) begin
          report_mismatch("luma_index", 32'(res.luma_index), 32'(want.luma_index));
        end
        if (res.chroma_valid !== want.chroma_valid) begin
          report_mismatch("chroma_valid", 32'(res.chroma_valid), 32'(want.chroma_valid));
        end
        if (res.blue_difference !== want.blue_difference) begin
          report_mismatch("blue_difference", 32'(res.blue_difference),
                          32'(want.blue_difference));
        end
        if (res.red_difference !== want.red_difference) begin
          report_mismatch("red_difference", 32'(res.red_difference),
                          32'(want.red_difference));
        end
        if (res.chroma_index !== want.chroma_index) begin
          report_mismatch("chroma_index", 32'(res.chroma_index), 32'(want.chroma_index));
        end
        if (res.frame_end !== want.frame_end) begin
          report_mismatch("frame_end", 32'(res.frame_end), 32'(want.frame_end));
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    pix.valid <= 1'b0;
    pix.blue  <= '0;
    pix.green <= '0;
    pix.red   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_small_frames();
    test_odd_widths();
    test_clamped_sizes();
    test_midframe_resize();
    test_backpressure();
    test_largest_frame();
    test_random_sizes();
    wait_for_results();
    // catch any stray word after the last one
    repeat (10) @(posedge clk);
    $display("Run covered %0d pixels over %0d frame sizes, widths 1 to 4096 with clamping.",
             pixels_sent, frame_settings);
    $display("Checked %0d words: %0d with chroma, %0d frame ends.",
             words_checked, chroma_seen, frame_ends_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/rtnv_pkg.sv
src/rtnv_pixel_if.sv
src/rtnv_result_if.sv
src/rtnv_config_regs.sv
src/rtnv_raster_counter.sv
src/rtnv_color_matrix.sv
src/rgb_to_nv12_converter.sv
tb/rgb_to_nv12_converter_test.sv
